[hw/rtl/cbm_pkg.sv]
// Shared types, command codes and constants for the cartridge bank mapper.
`timescale 1ns / 1ps

package cbm_pkg;

  // Command codes
  localparam logic [2:0] CMD_WRITE    = 3'd0;
  localparam logic [2:0] CMD_CYCLES   = 3'd1;
  localparam logic [2:0] CMD_SCANLINE = 3'd2;
  localparam logic [2:0] CMD_PRG      = 3'd3;
  localparam logic [2:0] CMD_CHR      = 3'd4;

  // Configuration register indexes
  localparam logic CFG_BOARD_VARIANT = 1'b0;
  localparam logic CFG_CHR_IS_RAM    = 1'b1;

  // Register write windows, by address[15:12]
  localparam logic [3:0] WIN_PRG   = 4'h8;
  localparam logic [3:0] WIN_OUTER = 4'h9;
  localparam logic [3:0] WIN_CHR_A = 4'hA;
  localparam logic [3:0] WIN_CHR_B = 4'hB;
  localparam logic [3:0] WIN_IRQ   = 4'hC;

  // IRQ register selects, by address[1:0]
  localparam logic [1:0] IRQ_CNT_LO = 2'd0;
  localparam logic [1:0] IRQ_CNT_HI = 2'd1;
  localparam logic [1:0] IRQ_MODE   = 2'd2;
  localparam logic [1:0] IRQ_ENABLE = 2'd3;

  localparam int BANK_W = 15;

  typedef logic [3:0][7:0] reg4_t;
  typedef logic [7:0][7:0] reg8_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  cycles;
  } in_word_t;

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic              irq_line;
    logic [1:0]        mirroring;
  } out_word_t;

  // PRG mask chosen by outer_regs[1][1:0]
  function automatic logic [7:0] prg_mask(input logic [1:0] sel);
    logic [7:0] m;
    case (sel)
      2'd0:    m = 8'h3F;
      2'd1:    m = 8'h1F;
      2'd2:    m = 8'h2F;
      default: m = 8'h0F;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/cartridge_bank_mapper_with_irq_core.sv]
// Cartridge bank mapper with cycle and scanline IRQ counters: top level.
//
// Takes one command word per clock while in_stall is low and returns one
// result word for each, in order. A word passes an input register, then one
// pass of register update and bank translation logic, then the result
// register, which holds the word while out_stall is high; the sustained
// rate is one word per cycle while out_stall is low. The input register fills
// while a result waits, so in_stall rises only when both stages are held.
// Configuration writes take effect at the next edge; the user must make them
// while no word is in flight, as the block itself does not enforce this.
`timescale 1ns / 1ps

module cartridge_bank_mapper_with_irq_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cbm_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output cbm_pkg::out_word_t  out_word,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic                cfg_data
);

  // Pipeline control
  logic              s1_valid;
  cbm_pkg::in_word_t s1_word;
  logic              advance;

  // Mapper state
  logic           board_variant;
  logic           chr_is_ram;
  cbm_pkg::reg4_t prg_regs;
  cbm_pkg::reg8_t chr_regs;
  cbm_pkg::reg4_t outer_regs;
  logic [15:0]    cycle_counter;
  logic [7:0]     line_latch;
  logic [7:0]     line_counter;
  logic           reload_flag;
  logic           irq_enabled;
  logic           scanline_mode;
  logic           auto_enable;
  logic           irq_pending;

  cbm_pkg::reg4_t prg_regs_next;
  cbm_pkg::reg8_t chr_regs_next;
  cbm_pkg::reg4_t outer_regs_next;
  logic [15:0]    cycle_counter_next;
  logic [7:0]     line_latch_next;
  logic [7:0]     line_counter_next;
  logic           reload_flag_next;
  logic           irq_enabled_next;
  logic           scanline_mode_next;
  logic           auto_enable_next;
  logic           irq_pending_next;

  logic [15:0] cycle_dec;
  logic [7:0]  line_step;
  logic [cbm_pkg::BANK_W-1:0] bank;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_word <= in_word;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      board_variant <= 1'b0;
      chr_is_ram    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        cbm_pkg::CFG_BOARD_VARIANT: board_variant <= cfg_data;
        default:                    chr_is_ram    <= cfg_data;
      endcase
    end
  end

  // Command execution: next state for the word in the input register
  assign cycle_dec = cycle_counter - {8'd0, s1_word.cycles};
  assign line_step = (line_counter == 8'd0 || reload_flag) ? line_latch
                                                           : line_counter - 8'd1;

  always_comb begin
    prg_regs_next      = prg_regs;
    chr_regs_next      = chr_regs;
    outer_regs_next    = outer_regs;
    cycle_counter_next = cycle_counter;
    line_latch_next    = line_latch;
    line_counter_next  = line_counter;
    reload_flag_next   = reload_flag;
    irq_enabled_next   = irq_enabled;
    scanline_mode_next = scanline_mode;
    auto_enable_next   = auto_enable;
    irq_pending_next   = irq_pending;
    case (s1_word.command)
      cbm_pkg::CMD_WRITE: begin
        unique case (s1_word.address[15:12])
          cbm_pkg::WIN_PRG: prg_regs_next[s1_word.address[1:0]] = s1_word.data;
          cbm_pkg::WIN_OUTER: outer_regs_next[s1_word.address[1:0]] = s1_word.data;
          cbm_pkg::WIN_CHR_A, cbm_pkg::WIN_CHR_B: begin
            chr_regs_next[{s1_word.address[12], s1_word.address[1:0]}] = s1_word.data;
          end
          cbm_pkg::WIN_IRQ: begin
            unique case (s1_word.address[1:0])
              cbm_pkg::IRQ_CNT_LO: begin
                if (auto_enable) irq_enabled_next = 1'b0;
                cycle_counter_next[7:0] = s1_word.data;
              end
              cbm_pkg::IRQ_CNT_HI: begin
                if (auto_enable) irq_enabled_next = 1'b1;
                cycle_counter_next[15:8] = s1_word.data;
                reload_flag_next = 1'b1;
                line_latch_next  = s1_word.data;
              end
              cbm_pkg::IRQ_MODE: begin
                irq_enabled_next   = s1_word.data[0];
                scanline_mode_next = s1_word.data[1];
                auto_enable_next   = s1_word.data[2];
              end
              default: irq_enabled_next = s1_word.data[0];
            endcase
            irq_pending_next = 1'b0;
          end
          default: ;
        endcase
      end
      cbm_pkg::CMD_CYCLES: begin
        // down-count only in cycle mode, while armed and while the counter is nonzero
        if (!scanline_mode && irq_enabled && cycle_counter != 16'd0) begin
          cycle_counter_next = cycle_dec;
          if (cycle_dec == 16'd0 || cycle_dec[15]) irq_pending_next = 1'b1;
        end
      end
      cbm_pkg::CMD_SCANLINE: begin
        if (scanline_mode) begin
          line_counter_next = line_step;
          if (line_step == 8'd0 && irq_enabled) irq_pending_next = 1'b1;
          reload_flag_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Lookups read the state as it stands before the word
  cbm_lookup u_lookup (
    .command       (s1_word.command),
    .address       (s1_word.address),
    .prg_regs      (prg_regs),
    .chr_regs      (chr_regs),
    .outer_regs    (outer_regs),
    .board_variant (board_variant),
    .chr_is_ram    (chr_is_ram),
    .bank          (bank)
  );

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_regs      <= {8'hFF, 8'hFE, 8'hFD, 8'hFC};
      chr_regs      <= {8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0};
      outer_regs    <= {8'h00, 8'h00, 8'h40, 8'h00};
      cycle_counter <= '0;
      line_latch    <= '0;
      line_counter  <= '0;
      reload_flag   <= 1'b0;
      irq_enabled   <= 1'b0;
      scanline_mode <= 1'b0;
      auto_enable   <= 1'b0;
      irq_pending   <= 1'b0;
    end else if (s1_valid && advance) begin
      prg_regs      <= prg_regs_next;
      chr_regs      <= chr_regs_next;
      outer_regs    <= outer_regs_next;
      cycle_counter <= cycle_counter_next;
      line_latch    <= line_latch_next;
      line_counter  <= line_counter_next;
      reload_flag   <= reload_flag_next;
      irq_enabled   <= irq_enabled_next;
      scanline_mode <= scanline_mode_next;
      auto_enable   <= auto_enable_next;
      irq_pending   <= irq_pending_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      out_word.bank      <= bank;
      out_word.irq_line  <= irq_pending_next;
      out_word.mirroring <= outer_regs_next[2][1:0];
    end
  end

endmodule

[hw/rtl/cbm_lookup.sv]
// Bank translation for PRG and CHR lookups, combinational.
`timescale 1ns / 1ps

module cbm_lookup (
  input  logic [2:0]                  command,
  input  logic [15:0]                 address,
  input  cbm_pkg::reg4_t              prg_regs,
  input  cbm_pkg::reg8_t              chr_regs,
  input  cbm_pkg::reg4_t              outer_regs,
  input  logic                        board_variant,
  input  logic                        chr_is_ram,
  output logic [cbm_pkg::BANK_W-1:0]  bank
);

  logic [7:0] prg_slot;
  logic [7:0] prg_masked;
  logic [6:0] prg_base;
  logic [7:0] chr_wide;
  logic [7:0] chr_narrow;
  logic [cbm_pkg::BANK_W-1:0] prg_bank;
  logic [cbm_pkg::BANK_W-1:0] chr_bank;

  // PRG: 8K slots from 0x6000, top slot fixed to the last bank
  always_comb begin
    case (address[15:13])
      3'd3:    prg_slot = prg_regs[3];
      3'd4:    prg_slot = prg_regs[0];
      3'd5:    prg_slot = prg_regs[1];
      3'd6:    prg_slot = prg_regs[2];
      default: prg_slot = 8'hFF;
    endcase
    prg_masked = prg_slot & cbm_pkg::prg_mask(outer_regs[1][1:0]);
    prg_base   = {outer_regs[0][5:3], 4'b0000};
    if (address < 16'h6000) begin
      prg_bank = '0;
    end else begin
      prg_bank = {7'd0, prg_masked | {1'b0, prg_base}};
    end
  end

  // CHR: 2K board uses regs 0,1,6,7; 1K board adds the outer CHR base
  always_comb begin
    case (address[12:11])
      2'd0:    chr_wide = chr_regs[0];
      2'd1:    chr_wide = chr_regs[1];
      2'd2:    chr_wide = chr_regs[6];
      default: chr_wide = chr_regs[7];
    endcase
    chr_narrow = chr_regs[address[12:10]] & (outer_regs[1][6] ? 8'hFF : 8'h7F);
    if (address[15:13] != 3'd0 || chr_is_ram) begin
      chr_bank = '0;
    end else if (board_variant) begin
      chr_bank = {7'd0, chr_wide};
    end else begin
      chr_bank = {outer_regs[3], 7'd0} | {7'd0, chr_narrow};
    end
  end

  always_comb begin
    case (command)
      cbm_pkg::CMD_PRG: bank = prg_bank;
      cbm_pkg::CMD_CHR: bank = chr_bank;
      default:          bank = '0;
    endcase
  end

endmodule

[hw/rtl/cbm_checker.sv]
// Port-level checks for the bank mapper core, bound to the top level.
`timescale 1ns / 1ps

module cbm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cbm_pkg::out_word_t out_word
);

  // Input side holds off only when the result register is full and held
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall raised with result side free");

  // An accepted word reaches the result register if the result side is free in the following cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("accepted word did not reach the result register");

  // A held result word stays put
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("result word changed while stalled");

  // No result right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind cartridge_bank_mapper_with_irq_core cbm_checker u_cbm_checker (.*);

[verif/cartridge_bank_mapper_with_irq_core_test.sv]
// Self-checking testbench for the cartridge bank mapper with IRQ counters.
`timescale 1ns / 1ps

module cartridge_bank_mapper_with_irq_core_test;
  import cbm_pkg::*;

  // Command codes the block accepts but ignores
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int MAX_PAUSE = 19;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_PHASE_WORDS = 200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_write = 1'b0;
  logic      cfg_index = CFG_BOARD_VARIANT;
  logic      cfg_data = 1'b0;

  cartridge_bank_mapper_with_irq_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Mapper state mirrored in the testbench
  logic [7:0]  prg_regs [4];
  logic [7:0]  chr_regs [8];
  logic [7:0]  outer [4];
  logic [15:0] cyc_cnt;
  logic [7:0]  line_latch;
  logic [7:0]  line_cnt;
  logic        reload_pend;
  logic        irq_en;
  logic        line_mode;
  logic        auto_en;
  logic        irq_pend;
  logic        board_wide;
  logic        chr_ram;

  out_word_t mapper_outputs_q [$];
  int        fail_count = 0;
  int        stall_left = 0;
  bit        gaps_on = 1'b1;
  bit        stalls_on = 1'b1;

  function automatic int pause_len(input bit enabled);
    return enabled ? $urandom_range(0, MAX_PAUSE) : 0;
  endfunction

  function automatic void load_reset_state();
    for (int i = 0; i < 4; i++) prg_regs[i] = 8'hFC + 8'(i);
    for (int i = 0; i < 8; i++) chr_regs[i] = 8'(i);
    outer[0] = 8'h00;
    outer[1] = 8'h40;
    outer[2] = 8'h00;
    outer[3] = 8'h00;
    cyc_cnt = '0;
    line_latch = '0;
    line_cnt = '0;
    reload_pend = 1'b0;
    irq_en = 1'b0;
    line_mode = 1'b0;
    auto_en = 1'b0;
    irq_pend = 1'b0;
    board_wide = 1'b0;
    chr_ram = 1'b0;
  endfunction

  // Apply one command word to the mirrored state and form its result word
  function automatic out_word_t mapper_step(input in_word_t w);
    out_word_t   r;
    logic [15:0] a;
    logic [7:0]  slot;
    logic [7:0]  mask;
    logic [7:0]  base;
    a = w.address;
    r = '0;
    case (w.command)
      CMD_WRITE: begin
        case (a[15:12])
          WIN_PRG:   prg_regs[a[1:0]] = w.data;
          WIN_OUTER: outer[a[1:0]] = w.data;
          WIN_CHR_A, WIN_CHR_B: chr_regs[{a[12], a[1:0]}] = w.data;
          WIN_IRQ: begin
            case (a[1:0])
              IRQ_CNT_LO: begin
                if (auto_en) irq_en = 1'b0;
                cyc_cnt[7:0] = w.data;
              end
              IRQ_CNT_HI: begin
                if (auto_en) irq_en = 1'b1;
                cyc_cnt[15:8] = w.data;
                reload_pend = 1'b1;
                line_latch = w.data;
              end
              IRQ_MODE: begin
                irq_en = w.data[0];
                line_mode = w.data[1];
                auto_en = w.data[2];
              end
              default: irq_en = w.data[0];
            endcase
            irq_pend = 1'b0;
          end
          default: ;
        endcase
      end
      CMD_CYCLES: begin
        // counter stopped at zero stays stopped
        if (!line_mode && irq_en && cyc_cnt != 16'h0000) begin
          cyc_cnt = cyc_cnt - {8'h00, w.cycles};
          if (cyc_cnt == 16'h0000 || cyc_cnt[15]) irq_pend = 1'b1;
        end
      end
      CMD_SCANLINE: begin
        if (line_mode) begin
          if (line_cnt == 8'h00 || reload_pend) line_cnt = line_latch;
          else line_cnt = line_cnt - 8'h01;
          if (line_cnt == 8'h00 && irq_en) irq_pend = 1'b1;
          reload_pend = 1'b0;
        end
      end
      CMD_PRG: begin
        if (a >= 16'h6000) begin
          case (outer[1][1:0])
            2'd0:    mask = 8'h3F;
            2'd1:    mask = 8'h1F;
            2'd2:    mask = 8'h2F;
            default: mask = 8'h0F;
          endcase
          case (a[15:13])
            3'd3:    slot = prg_regs[3];
            3'd4:    slot = prg_regs[0];
            3'd5:    slot = prg_regs[1];
            3'd6:    slot = prg_regs[2];
            default: slot = 8'hFF;
          endcase
          base = {2'b00, outer[0][5:3], 3'b000} << 1;
          r.bank = {7'b0, base | (slot & mask)};
        end
      end
      CMD_CHR: begin
        // pattern RAM and addresses past the pattern tables map to bank 0
        if (a < 16'h2000 && !chr_ram) begin
          if (board_wide) begin
            r.bank = {7'b0, chr_regs[{a[12], a[12], a[11]}]};
          end else begin
            mask = outer[1][6] ? 8'hFF : 8'h7F;
            r.bank = {outer[3], 7'b0} | {7'b0, chr_regs[a[12:10]] & mask};
          end
        end
      end
      default: ;
    endcase
    r.irq_line = irq_pend;
    r.mirroring = outer[2][1:0];
    return r;
  endfunction

  function automatic in_word_t make_word(input logic [2:0] cmd, input logic [15:0] addr,
                                         input logic [7:0] dat, input logic [7:0] cyc);
    in_word_t w;
    w.command = cmd;
    w.address = addr;
    w.data = dat;
    w.cycles = cyc;
    return w;
  endfunction

  // Mostly well-formed traffic; a small share of stray writes and spare commands
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    w = make_word(CMD_WRITE, 16'($urandom), 8'($urandom), 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      case ($urandom_range(0, 5))
        0:       w.address[15:12] = WIN_PRG;
        1:       w.address[15:12] = WIN_OUTER;
        2:       w.address[15:12] = WIN_CHR_A;
        3:       w.address[15:12] = WIN_CHR_B;
        default: w.address[15:12] = WIN_IRQ;
      endcase
      // small counter and latch values so interrupts actually fire
      if (w.address[15:12] == WIN_IRQ && $urandom_range(0, 1) == 1)
        w.data = 8'($urandom_range(0, 3));
    end else if (pick < 50) begin
      w.command = CMD_CYCLES;
    end else if (pick < 65) begin
      w.command = CMD_SCANLINE;
    end else if (pick < 80) begin
      w.command = CMD_PRG;
    end else if (pick < 93) begin
      w.command = CMD_CHR;
      if ($urandom_range(0, 3) != 0) w.address[15:13] = 3'b000;
    end else if ($urandom_range(0, 1) == 1) begin
      w.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
    return w;
  endfunction

  // Send one word; valid stays high into the next word when no gap is drawn
  task automatic send_word(input in_word_t w);
    int gap;
    gap = pause_len(gaps_on);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    mapper_outputs_q.push_back(mapper_step(w));
  endtask

  // Hold off the sender until every result is back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (mapper_outputs_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_board(input logic variant, input logic ram);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_BOARD_VARIANT;
    cfg_data <= variant;
    @(negedge clk);
    cfg_index <= CFG_CHR_IS_RAM;
    cfg_data <= ram;
    @(negedge clk);
    cfg_write <= 1'b0;
    board_wide = variant;
    chr_ram = ram;
  endtask

  // Receiver stall: a fresh hold is drawn after each accepted result
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (mapper_outputs_q.size() == 0) begin
        $error("result word with none outstanding: %h", out_word);
        fail_count++;
      end else begin
        want = mapper_outputs_q.pop_front();
        if (out_word.bank !== want.bank) begin
          $error("bank: expected %0d, got %0d", want.bank, out_word.bank);
          fail_count++;
        end
        if (out_word.irq_line !== want.irq_line) begin
          $error("irq_line: expected %0d, got %0d", want.irq_line, out_word.irq_line);
          fail_count++;
        end
        if (out_word.mirroring !== want.mirroring) begin
          $error("mirroring: expected %0d, got %0d", want.mirroring, out_word.mirroring);
          fail_count++;
        end
      end
      stall_left = pause_len(stalls_on);
    end
  end

  // Lookups in the power-on state at PRG and CHR window boundaries, plus a spare command
  task automatic test_reset_lookups();
    send_word(make_word(CMD_PRG, 16'h5FFF, 8'h00, 8'h00));
    send_word(make_word(CMD_PRG, 16'h6000, 8'hFF, 8'hFF));
    send_word(make_word(CMD_PRG, 16'h8000, 8'h00, 8'h00));
    send_word(make_word(CMD_PRG, 16'hA000, 8'h00, 8'h00));
    send_word(make_word(CMD_PRG, 16'hC000, 8'h00, 8'h00));
    send_word(make_word(CMD_PRG, 16'hFFFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_CHR, 16'h0000, 8'h00, 8'h00));
    send_word(make_word(CMD_CHR, 16'h1FFF, 8'h00, 8'h00));
    send_word(make_word(CMD_CHR, 16'h2000, 8'h00, 8'h00));
    send_word(make_word(CMD_SPARE_HI, 16'hFFFF, 8'hFF, 8'hFF));
  endtask

  // Cycle counter: stopped at zero, wrap past zero, stray write, then scanline reload
  task automatic test_irq_counters();
    send_word(make_word(CMD_WRITE, 16'hC002, 8'h01, 8'h00));
    send_word(make_word(CMD_CYCLES, 16'h0000, 8'h00, 8'h10));
    send_word(make_word(CMD_WRITE, 16'hC001, 8'h00, 8'h00));
    send_word(make_word(CMD_WRITE, 16'hC000, 8'h05, 8'h00));
    send_word(make_word(CMD_CYCLES, 16'h0000, 8'h00, 8'hFF));
    send_word(make_word(CMD_WRITE, 16'hD000, 8'hFF, 8'h00));
    send_word(make_word(CMD_WRITE, 16'hC003, 8'h00, 8'h00));
    send_word(make_word(CMD_WRITE, 16'hC002, 8'h03, 8'h00));
    send_word(make_word(CMD_WRITE, 16'hC001, 8'h01, 8'h00));
    send_word(make_word(CMD_SCANLINE, 16'h0000, 8'h00, 8'h00));
    send_word(make_word(CMD_SCANLINE, 16'h0000, 8'h00, 8'h00));
    send_word(make_word(CMD_CYCLES, 16'h0000, 8'h00, 8'h01));
  endtask

  // Random traffic under every board setting, idling patterns rotating
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      set_board(phase[0], phase[1]);
      for (int n = 0; n < RANDOM_PHASE_WORDS; n++) begin
        if (n % 50 == 0) begin
          case ((n / 50) % 4)
            0: begin gaps_on = 1'b1; stalls_on = 1'b1; end
            1: begin gaps_on = 1'b0; stalls_on = 1'b0; end
            2: begin gaps_on = 1'b1; stalls_on = 1'b0; end
            default: begin gaps_on = 1'b0; stalls_on = 1'b1; end
          endcase
        end
        send_word(random_word());
      end
    end
  endtask

  initial begin
    load_reset_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_lookups();
    test_irq_counters();
    test_random_traffic();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && mapper_outputs_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
